// ===== hw/rtl/wrm_pkg.sv =====
// ----------------------------------------------------------------------------
// wrm_pkg
// Shared types and constants of the windowed RMS level meter.
// ----------------------------------------------------------------------------
`default_nettype none

package wrm_pkg;

    localparam int SAMPLE_W       = 12;
    localparam int REG_W          = 13;
    localparam int SUM_W          = 32;
    localparam int QUOT_W         = 24;
    localparam int LEVEL_W        = 3;
    localparam int MASK_W         = 4;
    localparam int DIV_STEPS      = 2;
    localparam int SQRT_STEPS     = 6;
    localparam int QUEUE_DEPTH    = 2;
    localparam int WINDOW_LEN_DEF = 100;

    localparam logic [SAMPLE_W-1:0] CODE_MAX = 12'hFFF;

    localparam logic [REG_W-1:0] FULL_SCALE_RST  = 13'd3300;
    localparam logic [REG_W-1:0] LEVEL_ONE_RST   = 13'd990;
    localparam logic [REG_W-1:0] LEVEL_TWO_RST   = 13'd1650;
    localparam logic [REG_W-1:0] LEVEL_THREE_RST = 13'd2310;
    localparam logic [REG_W-1:0] LEVEL_FOUR_RST  = 13'd2970;

    typedef enum logic [2:0] {
        REG_FULL_SCALE  = 3'd0,
        REG_LEVEL_ONE   = 3'd1,
        REG_LEVEL_TWO   = 3'd2,
        REG_LEVEL_THREE = 3'd3,
        REG_LEVEL_FOUR  = 3'd4
    } wrm_reg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] full_scale;
        logic [REG_W-1:0] level_one;
        logic [REG_W-1:0] level_two;
        logic [REG_W-1:0] level_three;
        logic [REG_W-1:0] level_four;
    } wrm_cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } wrm_q_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/wrm_front.sv =====
// ----------------------------------------------------------------------------
// wrm_front
// Sample intake: circular window store and running sum of squares.
// ----------------------------------------------------------------------------
`default_nettype none

module wrm_front
    import wrm_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] sample_code,
    input  wire wrm_q_status_t       q_status,
    output logic                     push,
    output logic [SUM_W-1:0]         push_sum
);

    localparam int PosW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam logic [PosW-1:0] PosLast = PosW'(WINDOW_LEN - 1);

    typedef enum logic {F_IDLE, F_UPDATE} front_state_t;

    front_state_t          state_reg;
    logic [PosW-1:0]       pos_reg;
    logic                  wrapped_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [2*SAMPLE_W-1:0] sq_new_reg;
    logic [SAMPLE_W-1:0]   old_rd_reg;
    logic [SAMPLE_W-1:0]   window_mem [WINDOW_LEN];

    logic [SAMPLE_W-1:0]   old_code;
    logic [2*SAMPLE_W-1:0] sq_old;
    logic [SUM_W-1:0]      sum_next;
    logic                  accept;

    assign in_ready = (state_reg == F_IDLE) && !q_status.full;
    assign accept   = in_valid && in_ready;

    // Entries beyond the fill point have never been written and read as zero.
    assign old_code = wrapped_reg ? old_rd_reg : '0;
    assign sq_old   = (2*SAMPLE_W)'(old_code) * (2*SAMPLE_W)'(old_code);
    assign sum_next = sum_reg - SUM_W'(sq_old) + SUM_W'(sq_new_reg);

    assign push     = (state_reg == F_UPDATE);
    assign push_sum = sum_next;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            old_rd_reg <= window_mem[pos_reg];
        end
        if (state_reg == F_UPDATE)
        begin
            window_mem[pos_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (accept)
                    begin
                        sample_reg <= sample_code;
                        sq_new_reg <= (2*SAMPLE_W)'(sample_code) * (2*SAMPLE_W)'(sample_code);
                        state_reg  <= F_UPDATE;
                    end
                end
                F_UPDATE:
                begin
                    sum_reg <= sum_next;
                    if (pos_reg == PosLast)
                    begin
                        pos_reg     <= '0;
                        wrapped_reg <= 1'b1;
                    end
                    else
                    begin
                        pos_reg <= pos_reg + 1'b1;
                    end
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    // Once the window has filled, every entry stays valid.
    assert property (@(posedge clk) disable iff (!rst_n) wrapped_reg |=> wrapped_reg)
        else $error("window fill flag dropped");

endmodule

`default_nettype wire

// ===== hw/rtl/wrm_queue.sv =====
// ----------------------------------------------------------------------------
// wrm_queue
// Short queue of window sums between the intake and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wrm_queue
    import wrm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [SUM_W-1:0] push_sum,
    input  wire logic             pop,
    output logic [SUM_W-1:0]      pop_sum,
    output wrm_q_status_t         status
);

    localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(QUEUE_DEPTH + 1);

    logic [SUM_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg;
    logic [PtrW-1:0]  rd_ptr_reg;
    logic [CntW-1:0]  count_reg;

    assign status.full  = (count_reg == CntW'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_sum      = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) push |-> !status.full)
        else $error("sum pushed into a full queue");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !status.empty)
        else $error("sum popped from an empty queue");

endmodule

`default_nettype wire

// ===== hw/rtl/wrm_back.sv =====
// ----------------------------------------------------------------------------
// wrm_back
// Mean by window length, square root, millivolt scaling and bar graph.
// ----------------------------------------------------------------------------
`default_nettype none

module wrm_back
    import wrm_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire wrm_cfg_t            cfg,
    input  wire wrm_q_status_t       q_status,
    input  wire logic [SUM_W-1:0]    pop_sum,
    output logic                     pop,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [SAMPLE_W-1:0]      rms_code,
    output logic [SAMPLE_W-1:0]      rms_millivolts,
    output logic [LEVEL_W-1:0]       bar_level,
    output logic [MASK_W-1:0]        led_mask
);

    // The reciprocal is rounded up; its error times any 32-bit sum stays below
    // 2^40, so the floored product always equals the floored quotient.
    localparam int RecipShift = 40;
    localparam int RecipW     = RecipShift + 1;
    localparam int RecipLoW   = 21;
    localparam int RecipHiW   = RecipW - RecipLoW;
    localparam logic [63:0] RecipFull =
        ((64'd1 << RecipShift) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RecipLoW-1:0] RecipLo = RecipFull[RecipLoW-1:0];
    localparam logic [RecipHiW-1:0] RecipHi = RecipFull[RecipW-1:RecipLoW];

    typedef enum logic [2:0] {B_IDLE, B_DIV, B_SQRT, B_SCALE, B_DONE} back_state_t;

    back_state_t                 state_reg;
    logic [3:0]                  cnt_reg;
    logic [SUM_W-1:0]            sum_reg;
    logic [SUM_W+RecipLoW-1:0]   part_lo_reg;
    logic [SUM_W+RecipHiW-1:0]   part_hi_reg;
    logic [QUOT_W-1:0]           v_reg;
    logic [QUOT_W-1:0]           root_reg;
    logic [QUOT_W-1:0]           bit_reg;
    logic [SAMPLE_W-1:0]         code_reg;
    logic [SAMPLE_W-1:0]         mv_reg;
    logic                        out_valid_reg;
    logic [SAMPLE_W-1:0]         rms_code_reg;
    logic [SAMPLE_W-1:0]         rms_mv_reg;
    logic [LEVEL_W-1:0]          bar_level_reg;
    logic [MASK_W-1:0]           led_mask_reg;

    logic [SUM_W+RecipLoW-1:0]   part_lo;
    logic [SUM_W+RecipHiW-1:0]   part_hi;
    logic [SUM_W+RecipW-1:0]     recip_prod;
    logic [QUOT_W-1:0]           mean_next;

    logic [QUOT_W:0]     sq_try1;
    logic [QUOT_W-1:0]   sq_v1;
    logic [QUOT_W-1:0]   sq_root1;
    logic [QUOT_W-1:0]   sq_bit1;
    logic [QUOT_W:0]     sq_try2;
    logic [QUOT_W-1:0]   v_next;
    logic [QUOT_W-1:0]   root_next;

    logic [REG_W+SAMPLE_W-1:0] mv_prod;
    logic [REG_W-1:0]          mv_full;
    logic [SAMPLE_W-1:0]       mv_next;
    logic [LEVEL_W-1:0]        level_next;
    logic [MASK_W-1:0]         mask_next;
    logic                      out_free;

    // The mean is formed from both partial products, registered, then their sum.
    assign part_lo    = (SUM_W+RecipLoW)'(sum_reg) * (SUM_W+RecipLoW)'(RecipLo);
    assign part_hi    = (SUM_W+RecipHiW)'(sum_reg) * (SUM_W+RecipHiW)'(RecipHi);
    assign recip_prod = {part_hi_reg, {RecipLoW{1'b0}}} + (SUM_W+RecipW)'(part_lo_reg);
    assign mean_next  = recip_prod[RecipShift +: QUOT_W];

    // Two iterations of the bit-by-bit square root a cycle.
    always_comb
    begin
        sq_try1 = (QUOT_W+1)'(root_reg) + (QUOT_W+1)'(bit_reg);
        if ((QUOT_W+1)'(v_reg) >= sq_try1)
        begin
            sq_v1    = v_reg - sq_try1[QUOT_W-1:0];
            sq_root1 = (root_reg >> 1) + bit_reg;
        end
        else
        begin
            sq_v1    = v_reg;
            sq_root1 = root_reg >> 1;
        end
        sq_bit1 = bit_reg >> 2;
        sq_try2 = (QUOT_W+1)'(sq_root1) + (QUOT_W+1)'(sq_bit1);
        if ((QUOT_W+1)'(sq_v1) >= sq_try2)
        begin
            v_next    = sq_v1 - sq_try2[QUOT_W-1:0];
            root_next = (sq_root1 >> 1) + sq_bit1;
        end
        else
        begin
            v_next    = sq_v1;
            root_next = sq_root1 >> 1;
        end
    end

    // Full scales of 4098 mV and above can push the product past the output range.
    assign mv_prod = (REG_W+SAMPLE_W)'(cfg.full_scale) * (REG_W+SAMPLE_W)'(code_reg);
    assign mv_full = mv_prod[REG_W+SAMPLE_W-1:SAMPLE_W];
    assign mv_next = (mv_full > REG_W'(CODE_MAX)) ? CODE_MAX : mv_full[SAMPLE_W-1:0];

    // The thresholds need not be ordered, so each one met counts.
    always_comb
    begin
        level_next = LEVEL_W'({2'b00, (REG_W'(mv_reg) >= cfg.level_one)})
                   + LEVEL_W'({2'b00, (REG_W'(mv_reg) >= cfg.level_two)})
                   + LEVEL_W'({2'b00, (REG_W'(mv_reg) >= cfg.level_three)})
                   + LEVEL_W'({2'b00, (REG_W'(mv_reg) >= cfg.level_four)});
        case (level_next)
            3'd0:    mask_next = 4'b0000;
            3'd1:    mask_next = 4'b0001;
            3'd2:    mask_next = 4'b0011;
            3'd3:    mask_next = 4'b0111;
            3'd4:    mask_next = 4'b1111;
            default: mask_next = 4'b0000;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;
    assign pop      = (state_reg == B_IDLE) && !q_status.empty;

    assign out_valid      = out_valid_reg;
    assign rms_code       = rms_code_reg;
    assign rms_millivolts = rms_mv_reg;
    assign bar_level      = bar_level_reg;
    assign led_mask       = led_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == B_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE:
                begin
                    if (pop)
                    begin
                        sum_reg   <= pop_sum;
                        cnt_reg   <= '0;
                        state_reg <= B_DIV;
                    end
                end
                B_DIV:
                begin
                    if (cnt_reg == 4'(DIV_STEPS - 1))
                    begin
                        v_reg     <= mean_next;
                        root_reg  <= '0;
                        bit_reg   <= {2'b01, {(QUOT_W-2){1'b0}}};
                        cnt_reg   <= '0;
                        state_reg <= B_SQRT;
                    end
                    else
                    begin
                        part_lo_reg <= part_lo;
                        part_hi_reg <= part_hi;
                        cnt_reg     <= cnt_reg + 1'b1;
                    end
                end
                B_SQRT:
                begin
                    v_reg    <= v_next;
                    root_reg <= root_next;
                    bit_reg  <= bit_reg >> 4;
                    if (cnt_reg == 4'(SQRT_STEPS - 1))
                    begin
                        code_reg  <= root_next[SAMPLE_W-1:0];
                        state_reg <= B_SCALE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                B_SCALE:
                begin
                    mv_reg    <= mv_next;
                    state_reg <= B_DONE;
                end
                B_DONE:
                begin
                    if (out_free)
                    begin
                        rms_code_reg  <= code_reg;
                        rms_mv_reg    <= mv_reg;
                        bar_level_reg <= level_next;
                        led_mask_reg  <= mask_next;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

    // The root's trial bit must not run out before the last iteration pair.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_SQRT) |-> (bit_reg != '0))
        else $error("square root ran past its last bit");

    // A finished result never overwrites one that has not been taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DONE && out_valid_reg && !out_ready) |=> (state_reg == B_DONE))
        else $error("result loaded over a waiting beat");

endmodule

`default_nettype wire

// ===== hw/rtl/windowed_rms_level_meter.sv =====
// ----------------------------------------------------------------------------
// windowed_rms_level_meter
// Moving-window RMS of ADC samples with millivolt scaling and a bar graph.
// ----------------------------------------------------------------------------
// Each accepted sample beat replaces the oldest sample of a window of
// WINDOW_LEN samples (zero after reset) and yields one result beat: the RMS
// code, that code in millivolts, a bar level of 0 to 4 and its thermometer LED
// mask. The intake reads the oldest window entry, then updates the sum, and
// hands the running sum of squares to a two-entry queue. The back end loads a
// sum, forms the mean (a multiply by the window length's reciprocal, then the
// sum of its partial products), takes the square root (two root bits a
// cycle), then does the millivolt multiply and the thresholds. The sustained
// rate is set by the back end; the intake takes new samples while it works,
// until the queue is full. The output register lets the next sample proceed
// while a result waits. The configuration channel is always ready; writes to
// indexes 5 to 7 are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_rms_level_meter
    import wrm_pkg::*;
#(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [SAMPLE_W-1:0] sample_code,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [SAMPLE_W-1:0]      rms_code,
    output logic [SAMPLE_W-1:0]      rms_millivolts,
    output logic [LEVEL_W-1:0]       bar_level,
    output logic [MASK_W-1:0]        led_mask,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [REG_W-1:0]    cfg_data
);

    wrm_cfg_t         cfg_reg;
    wrm_q_status_t    q_status;
    logic             push;
    logic             pop;
    logic [SUM_W-1:0] push_sum;
    logic [SUM_W-1:0] pop_sum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_scale  <= FULL_SCALE_RST;
            cfg_reg.level_one   <= LEVEL_ONE_RST;
            cfg_reg.level_two   <= LEVEL_TWO_RST;
            cfg_reg.level_three <= LEVEL_THREE_RST;
            cfg_reg.level_four  <= LEVEL_FOUR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_FULL_SCALE:  cfg_reg.full_scale  <= cfg_data;
                REG_LEVEL_ONE:   cfg_reg.level_one   <= cfg_data;
                REG_LEVEL_TWO:   cfg_reg.level_two   <= cfg_data;
                REG_LEVEL_THREE: cfg_reg.level_three <= cfg_data;
                REG_LEVEL_FOUR:  cfg_reg.level_four  <= cfg_data;
                default:         ;
            endcase
        end
    end

    wrm_front #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_code (sample_code),
        .q_status    (q_status),
        .push        (push),
        .push_sum    (push_sum)
    );

    wrm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_sum (push_sum),
        .pop      (pop),
        .pop_sum  (pop_sum),
        .status   (q_status)
    );

    wrm_back #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .q_status       (q_status),
        .pop_sum        (pop_sum),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rms_code       (rms_code),
        .rms_millivolts (rms_millivolts),
        .bar_level      (bar_level),
        .led_mask       (led_mask)
    );

endmodule

`default_nettype wire
